FILE: hdl/cse_pkg.sv
package cse_pkg;

  // Character codes used by the escaper.
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // Longest escape: two-character introducer plus three octal digits.
  localparam int unsigned MaxChars = 5;
  localparam int unsigned CntW     = $clog2(MaxChars + 1);

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BACKSLASH_MODE     = 3'd0,
    CFG_SINGLE_QUOTE_MODE  = 3'd1,
    CFG_DOUBLE_QUOTE_MODE  = 3'd2,
    CFG_WHITESPACE_MODE    = 3'd3,
    CFG_DOUBLED_INTRODUCER = 3'd4
  } cfg_idx_e;

  // Mode codes shared by the per-character mode registers.
  typedef enum logic [1:0] {
    MODE_ESCAPE    = 2'd0,
    MODE_ECHO      = 2'd1,
    MODE_OCTAL     = 2'd2,
    MODE_STRINGIZE = 2'd3
  } mode_e;

  // How one byte is rendered.
  typedef enum logic [1:0] {
    K_ECHO,   // byte as is
    K_FIXED,  // one backslash, then a character
    K_INTRO,  // introducer, then a character
    K_OCTAL   // introducer, then octal digits
  } kind_e;

  typedef struct packed {
    mode_e      backslash_mode;
    mode_e      single_quote_mode;
    mode_e      double_quote_mode;
    mode_e      whitespace_mode;
    logic       doubled_introducer;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       starts_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_byte;
  } out_beat_t;

  // Encoded form of one byte, left aligned in chars[0].
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntW-1:0]          count;
    logic                     octal;
  } enc_t;

  // Letter of the named whitespace escape.
  function automatic logic [7:0] ws_name(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'd9:    c = 8'h74;  // t
      8'd10:   c = 8'h6E;  // n
      8'd11:   c = 8'h76;  // v
      8'd12:   c = 8'h66;  // f
      8'd13:   c = 8'h72;  // r
      default: c = 8'h74;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/cse_stream_if.sv
interface cse_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/cse_encoder.sv
module cse_encoder
  import cse_pkg::*;
(
  input  logic [7:0] in_byte_i,
  input  logic       starts_string_i,
  input  logic       prev_octal_i,
  input  cfg_t       cfg_i,
  output enc_t       enc_o
);

  kind_e      kind;
  logic [7:0] body_c;
  logic       prev_oct;
  logic [1:0] intro_n;
  logic [1:0] body_n;
  logic [2:0][7:0] body;
  logic [2:0] rel;

  assign prev_oct = prev_octal_i & ~starts_string_i;

  // Classify the byte in priority order.
  always_comb begin
    kind   = K_ECHO;
    body_c = in_byte_i;
    if (in_byte_i == CH_BSL) begin
      case (cfg_i.backslash_mode)
        MODE_ECHO:  kind = K_ECHO;
        MODE_OCTAL: kind = K_OCTAL;
        default:    kind = K_FIXED;
      endcase
    end else if (in_byte_i == CH_SQ) begin
      case (cfg_i.single_quote_mode)
        MODE_ECHO:  kind = K_ECHO;
        MODE_OCTAL: kind = K_OCTAL;
        default:    kind = K_INTRO;
      endcase
    end else if (in_byte_i == CH_DQ) begin
      case (cfg_i.double_quote_mode)
        MODE_ECHO:      kind = K_ECHO;
        MODE_OCTAL:     kind = K_OCTAL;
        MODE_STRINGIZE: kind = K_FIXED;
        default:        kind = K_INTRO;
      endcase
    end else if (in_byte_i == CH_SPACE || in_byte_i inside {[8'd9:8'd13]}) begin
      if (cfg_i.whitespace_mode == MODE_ECHO || in_byte_i == CH_SPACE) begin
        kind = K_ECHO;
      end else if (cfg_i.whitespace_mode == MODE_OCTAL) begin
        kind = K_OCTAL;
      end else begin
        kind   = K_INTRO;
        body_c = ws_name(in_byte_i);
      end
    end else if (prev_oct && in_byte_i inside {[CH_ZERO:CH_SEVEN]}) begin
      kind = K_OCTAL;
    end else if (in_byte_i == CH_BEL) begin
      kind   = K_INTRO;
      body_c = 8'h61;  // a
    end else if (in_byte_i == CH_BS) begin
      kind   = K_INTRO;
      body_c = 8'h62;  // b
    end else if (in_byte_i < CH_SPACE || in_byte_i > CH_TILDE) begin
      kind = K_OCTAL;
    end
  end

  // Introducer length and body characters.
  always_comb begin
    case (kind)
      K_ECHO:  intro_n = 2'd0;
      K_FIXED: intro_n = 2'd1;
      default: intro_n = 2'd1 + {1'b0, cfg_i.doubled_introducer};
    endcase
    body = '0;
    if (kind == K_OCTAL) begin
      // Unpadded octal: drop leading zero digits.
      if (in_byte_i >= 8'd64) begin
        body_n  = 2'd3;
        body[0] = {6'b001100, in_byte_i[7:6]};
        body[1] = {5'b00110, in_byte_i[5:3]};
        body[2] = {5'b00110, in_byte_i[2:0]};
      end else if (in_byte_i >= 8'd8) begin
        body_n  = 2'd2;
        body[0] = {5'b00110, in_byte_i[5:3]};
        body[1] = {5'b00110, in_byte_i[2:0]};
      end else begin
        body_n  = 2'd1;
        body[0] = {5'b00110, in_byte_i[2:0]};
      end
    end else begin
      body_n  = 2'd1;
      body[0] = body_c;
    end
  end

  // Assemble introducer and body into the character slots.
  always_comb begin
    enc_o.count = CntW'(intro_n) + CntW'(body_n);
    enc_o.octal = (kind == K_OCTAL);
    rel         = '0;
    for (int p = 0; p < MaxChars; p++) begin
      rel = 3'(p) - {1'b0, intro_n};
      if (3'(p) < {1'b0, intro_n}) begin
        enc_o.chars[p] = CH_BSL;
      end else if (rel < 3'd3) begin
        enc_o.chars[p] = body[rel[1:0]];
      end else begin
        enc_o.chars[p] = '0;
      end
    end
  end

endmodule

FILE: hdl/cse_serializer.sv
module cse_serializer
  import cse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  enc_t      enc_i,
  output logic      load_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic [MaxChars-1:0][7:0] chars_q, chars_d;
  logic [CntW-1:0]          rem_q, rem_d;
  logic                     beat;

  assign out_valid_o  = (rem_q != '0);
  assign beat         = out_valid_o & out_ready_i;
  // Free when empty or when the final character leaves in this cycle.
  assign load_ready_o = (rem_q == '0) || (beat && rem_q == CntW'(1));

  assign out_beat_o.out_char     = chars_q[0];
  assign out_beat_o.last_of_byte = (rem_q == CntW'(1));

  // Shift one character out per beat; load a new byte when free.
  always_comb begin
    chars_d = chars_q;
    rem_d   = rem_q;
    if (beat) begin
      chars_d = {8'h00, chars_q[MaxChars-1:1]};
      rem_d   = rem_q - CntW'(1);
    end
    if (load_i) begin
      chars_d = enc_i.chars;
      rem_d   = enc_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

FILE: hdl/c_string_escaper.sv
// Channel  | Dir | Payload                        | Beat when
// in_if    | in  | in_byte[8], starts_string[1]   | valid && ready
// out_if   | out | out_char[8], last_of_byte[1]   | valid && ready
// cfg      | in  | cfg_idx_i[3], cfg_data_i[2]    | cfg_we_i
//
// A byte is encoded in the cycle it is accepted and its one to five characters
// leave one per cycle from the output shift register while the output is ready.
// A new byte is taken in the cycle the last character of the previous one
// leaves. Reset clears the configuration to zero, the octal memory and the
// output register's character count. A stalled output holds the current
// character and back-pressures the input.
module c_string_escaper
  import cse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cse_stream_if.sink          in_if,
  cse_stream_if.source        out_if
);

  cfg_t     cfg_q;
  logic     prev_octal_q, prev_octal_d;
  logic     in_beat;
  logic     load_ready;
  enc_t     enc;
  in_beat_t in_pl;
  out_beat_t out_pl;

  assign in_pl        = in_if.payload;
  assign in_if.ready  = load_ready;
  assign in_beat      = in_if.valid & load_ready;
  assign out_if.payload = out_pl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{MODE_ESCAPE, MODE_ESCAPE, MODE_ESCAPE, MODE_ESCAPE, 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BACKSLASH_MODE:     cfg_q.backslash_mode     <= mode_e'(cfg_data_i);
        CFG_SINGLE_QUOTE_MODE:  cfg_q.single_quote_mode  <= mode_e'(cfg_data_i);
        CFG_DOUBLE_QUOTE_MODE:  cfg_q.double_quote_mode  <= mode_e'(cfg_data_i);
        CFG_WHITESPACE_MODE:    cfg_q.whitespace_mode    <= mode_e'(cfg_data_i);
        CFG_DOUBLED_INTRODUCER: cfg_q.doubled_introducer <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Octal memory follows every accepted byte.
  assign prev_octal_d = in_beat ? enc.octal : prev_octal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_octal_q <= 1'b0;
    end else begin
      prev_octal_q <= prev_octal_d;
    end
  end

  cse_encoder u_encoder (
    .in_byte_i      (in_pl.in_byte),
    .starts_string_i(in_pl.starts_string),
    .prev_octal_i   (prev_octal_q),
    .cfg_i          (cfg_q),
    .enc_o          (enc)
  );

  cse_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_beat),
    .enc_i       (enc),
    .load_ready_o(load_ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_beat_o  (out_pl)
  );

`ifndef NO_ASSERTIONS
  // An empty output register always takes a new byte.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled while output is empty");

  // Every accepted byte produces a character in the next cycle.
  a_accept_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> out_if.valid)
    else $error("accepted byte produced no character");

  // A byte's characters continue until its last one has gone.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && !out_pl.last_of_byte) |=> out_if.valid)
    else $error("character sequence cut short");

  // No new byte is taken while a non-final character is pending.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_pl.last_of_byte) |-> !in_if.ready)
    else $error("input taken while characters remain");
`endif

endmodule
